@@ hdl/fse_pkg.sv @@
// Shared types and character constants for the format string expander.
// Used by fse_bcd and format_string_expander; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package fse_pkg;

	// ASCII codes the expander recognizes or produces
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// Decimal digits held by the converter (2^31 has ten digits)
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned BIN_W      = 32;

	// Escape waiting for its second byte
	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_BSL  = 2'd1,
		MODE_PCT  = 2'd2
	} mode_t;

	// Top level sequencer states
	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_LIT  = 2'd1,
		S_DEC  = 2'd2
	} state_t;

	// Converter phases
	typedef enum logic [1:0] {
		B_IDLE  = 2'd0,
		B_CONV  = 2'd1,
		B_STRIP = 2'd2,
		B_EMIT  = 2'd3
	} bcd_phase_t;

	// Digit offered by the converter to the sequencer
	typedef struct packed {
		logic       valid;
		logic       last;
		logic [3:0] digit;
	} bcd_stat_t;

endpackage

`default_nettype wire

@@ hdl/format_string_expander.sv @@
// Top level of the format string expander: escape decoding, byte sequencing
// and the output register. Depends on fse_pkg and fse_bcd.
//
// Usage: one format byte with its 32-bit argument enters per beat on the
// s_ group. The expansion leaves on the m_ group, one byte per beat, with
// m_tlast high on the final byte of an item; an item that opens an escape
// gives no beat at all. s_tready is high only while the sequencer is idle.
// Sequencing: a literal byte waits in the literal queue and moves to the
// output register from S_LIT whenever that register is free. A %d item
// goes through the accept cycle, shift-add-3 conversion of all 32 input
// bits, dropping of leading zero digits, and then readout of the digits.
// Dropped and shown digits always add up to ten. A minus sign goes out
// during conversion. The output register lets the next item be taken
// while the last byte of the previous one waits. When the receiver holds
// m_tready low the sequencer simply waits; nothing is dropped.
// Reset clears the pending escape and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module format_string_expander (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// fmt_char [7:0], arg_value [39:8]
	input  wire logic [39:0] s_tdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// out_char [7:0]
	output logic [7:0]       m_tdata,
	output logic             m_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready
);
	import fse_pkg::*;

	state_t      state_q, state_d;
	mode_t       mode_q, mode_d;
	logic [7:0]  lit0_q, lit1_q, lit0_d, lit1_d;
	logic [1:0]  lit_cnt_q, lit_cnt_d;

	logic [7:0]  fmt_char;
	logic [31:0] arg_value;
	logic        accept;

	// Decode results for the incoming byte
	mode_t       dec_mode, plain_mode;
	logic        plain_emit;
	logic [7:0]  dec_lit0, dec_lit1;
	logic [1:0]  dec_cnt;
	logic        dec_num;
	logic        arg_neg;
	logic [31:0] arg_mag;

	// Output register
	logic        out_valid_q;
	logic [7:0]  out_char_q;
	logic        out_last_q;
	logic        out_free, out_load;
	logic [7:0]  out_char_d;
	logic        out_last_d;

	bcd_stat_t   bcd_stat;
	logic        bcd_take;

	assign fmt_char  = s_tdata[7:0];
	assign arg_value = s_tdata[39:8];
	assign accept    = s_tvalid && s_tready;
	assign arg_neg   = arg_value[31];
	assign arg_mag   = arg_neg ? (32'd0 - arg_value) : arg_value;

	// Byte handled with nothing pending
	always_comb begin
		plain_mode = MODE_NONE;
		plain_emit = 1'b1;
		if (fmt_char == CH_BSL) begin
			plain_mode = MODE_BSL;
			plain_emit = 1'b0;
		end else if (fmt_char == CH_PCT) begin
			plain_mode = MODE_PCT;
			plain_emit = 1'b0;
		end
	end

	// Escape decoding against the pending mode
	always_comb begin
		dec_mode = MODE_NONE;
		dec_lit0 = fmt_char;
		dec_lit1 = fmt_char;
		dec_cnt  = 2'd0;
		dec_num  = 1'b0;
		case (mode_q)
			MODE_BSL: begin
				if (fmt_char == CH_N) begin
					dec_lit0 = CH_NL;
					dec_cnt  = 2'd1;
				end else if (fmt_char == CH_BSL) begin
					dec_lit0 = CH_BSL;
					dec_cnt  = 2'd1;
				end else begin
					dec_lit0 = CH_BSL;
					dec_cnt  = {1'b0, 1'b1} + {1'b0, plain_emit};
					dec_mode = plain_mode;
				end
			end
			MODE_PCT: begin
				if (fmt_char == CH_PCT) begin
					dec_lit0 = CH_PCT;
					dec_cnt  = 2'd1;
				end else if (fmt_char == CH_D) begin
					dec_num  = 1'b1;
					dec_lit0 = CH_MINUS;
					dec_cnt  = {1'b0, arg_neg};
				end else begin
					dec_lit0 = CH_PCT;
					dec_cnt  = {1'b0, 1'b1} + {1'b0, plain_emit};
					dec_mode = plain_mode;
				end
			end
			default: begin
				dec_cnt  = {1'b0, plain_emit};
				dec_mode = plain_mode;
			end
		endcase
	end

	assign out_free = !out_valid_q || m_tready;

	// Sequencer: next state, literal queue and output register load
	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		lit0_d     = lit0_q;
		lit1_d     = lit1_q;
		lit_cnt_d  = lit_cnt_q;
		s_tready   = 1'b0;
		out_load   = 1'b0;
		out_char_d = lit0_q;
		out_last_d = 1'b0;
		bcd_take   = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					mode_d    = dec_mode;
					lit0_d    = dec_lit0;
					lit1_d    = dec_lit1;
					lit_cnt_d = dec_cnt;
					if (dec_num) begin
						state_d = S_DEC;
					end else if (dec_cnt != 2'd0) begin
						state_d = S_LIT;
					end
				end
			end
			S_LIT: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_last_d = (lit_cnt_q == 2'd1);
					lit0_d     = lit1_q;
					lit_cnt_d  = lit_cnt_q - 2'd1;
					if (lit_cnt_q == 2'd1) begin
						state_d = S_IDLE;
					end
				end
			end
			S_DEC: begin
				// Sign first, then the digits as the converter offers them
				if (out_free) begin
					if (lit_cnt_q != 2'd0) begin
						out_load  = 1'b1;
						lit_cnt_d = lit_cnt_q - 2'd1;
					end else if (bcd_stat.valid) begin
						out_load   = 1'b1;
						bcd_take   = 1'b1;
						out_char_d = CH_ZERO + {4'd0, bcd_stat.digit};
						out_last_d = bcd_stat.last;
						if (bcd_stat.last) begin
							state_d = S_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_NONE;
			lit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			mode_q    <= mode_d;
			lit_cnt_q <= lit_cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		lit0_q <= lit0_d;
		lit1_q <= lit1_d;
		if (out_load) begin
			out_char_q <= out_char_d;
			out_last_q <= out_last_d;
		end
	end

	fse_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && dec_num),
		.mag    (arg_mag),
		.take   (bcd_take),
		.stat   (bcd_stat)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;

	// The converter never offers a digit while the sequencer is idle
	a_bcd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !bcd_stat.valid)
		else $error("converter offers a digit while idle");

	// A digit is never taken ahead of a pending sign
	a_sign_first: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_take |-> lit_cnt_q == 2'd0)
		else $error("digit taken before sign");

	// The literal queue holds at most two bytes
	a_lit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		lit_cnt_q != 2'd3)
		else $error("literal queue overflow");

	// A decimal item starts the converter in the next cycle
	a_dec_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && dec_num) |=> (state_q == S_DEC && !bcd_stat.valid))
		else $error("decimal item did not start conversion");

endmodule

`default_nettype wire

@@ hdl/fse_bcd.sv @@
// Bit-serial binary to BCD converter with digit-serial readout.
// Depends on fse_pkg for the phase enum, the status struct and the widths.
`timescale 1ns / 1ps
`default_nettype none

module fse_bcd (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [31:0]         mag,
	input  wire logic                take,
	output fse_pkg::bcd_stat_t       stat
);
	import fse_pkg::*;

	localparam int unsigned BCD_W = 4 * NUM_DIGITS;

	bcd_phase_t         phase_q;
	logic [BIN_W-1:0]   bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [4:0]         cnt_q;
	logic [3:0]         dig_q;
	logic [BCD_W-1:0]   adj;
	logic [3:0]         top_digit;

	// Add three to every digit of five or more before the next shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];

	// Status toward the sequencer
	always_comb begin
		stat.valid = (phase_q == B_EMIT);
		stat.last  = (dig_q == 4'd1);
		stat.digit = top_digit;
	end

	// Control: one input bit per cycle, then leading zero digits dropped, then one digit per cycle while take is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= B_IDLE;
			cnt_q   <= '0;
			dig_q   <= '0;
		end else begin
			case (phase_q)
				B_IDLE: begin
					if (start) begin
						phase_q <= B_CONV;
						cnt_q   <= 5'(BIN_W - 1);
						dig_q   <= 4'(NUM_DIGITS);
					end
				end
				B_CONV: begin
					if (cnt_q == 5'd0) begin
						phase_q <= B_STRIP;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				B_STRIP: begin
					if (top_digit == 4'd0 && dig_q != 4'd1) begin
						dig_q <= dig_q - 4'd1;
					end else begin
						phase_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (take) begin
						dig_q <= dig_q - 4'd1;
						if (dig_q == 4'd1) begin
							phase_q <= B_IDLE;
						end
					end
				end
				default: begin
					phase_q <= B_IDLE;
				end
			endcase
		end
	end

	// Datapath shift registers
	always_ff @(posedge clk) begin
		case (phase_q)
			B_IDLE: begin
				if (start) begin
					bin_q <= mag;
					bcd_q <= '0;
				end
			end
			B_CONV: begin
				bcd_q <= {adj[BCD_W-2:0], bin_q[BIN_W-1]};
				bin_q <= {bin_q[BIN_W-2:0], 1'b0};
			end
			B_STRIP: begin
				if (top_digit == 4'd0 && dig_q != 4'd1) begin
					bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
				end
			end
			B_EMIT: begin
				if (take) begin
					bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
				end
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

endmodule

`default_nettype wire
